// ===== src/iolsu_pkg.sv =====
// Shared types and constants for the indexed ordered list store.
package iolsu_pkg;

  localparam int CAPACITY = 64;
  localparam int LANE     = 8;
  localparam int DATA_W   = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_APPEND     = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_GET        = 3'd3;
  localparam logic [2:0] OP_FIND       = 3'd4;
  localparam logic [2:0] OP_LENGTH     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic        [2:0]        operation;
    logic signed [DATA_W-1:0] value;
    logic        [6:0]        position;
  } req_t;

  typedef struct packed {
    logic        [2:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic        [5:0]        found_position;
    logic        [6:0]        length;
  } rsp_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [DATA_W-1:0] data;
  } scan_res_t;

endpackage

// ===== src/iolsu_cell.sv =====
// One list cell: holds an entry, shifts from its left neighbour, flags a match.
module iolsu_cell #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                             clk_i,
  input  logic                             upd_i,
  input  logic [CNT_W-1:0]                 ins_pos_i,
  input  logic [iolsu_pkg::DATA_W-1:0]     value_i,
  input  logic [iolsu_pkg::DATA_W-1:0]     left_i,
  input  logic [CNT_W-1:0]                 count_i,
  input  logic                             find_i,
  input  logic [iolsu_pkg::DATA_W-1:0]     key_i,
  input  logic [CNT_W-1:0]                 rd_pos_i,
  output logic [iolsu_pkg::DATA_W-1:0]     entry_o,
  output logic                             match_o
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [iolsu_pkg::DATA_W-1:0] entry_q;

  // Take the new value at the insert point, shift right behind it.
  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      if (MY_IDX == ins_pos_i) begin
        entry_q <= value_i;
      end else if (MY_IDX > ins_pos_i) begin
        entry_q <= left_i;
      end
    end
  end

  always_comb begin
    if (find_i) begin
      match_o = (MY_IDX < count_i) && (entry_q == key_i);
    end else begin
      match_o = (MY_IDX == rd_pos_i);
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== src/iolsu_scan.sv =====
// Lane-by-lane scan over the cell match flags: first match and its entry.
module iolsu_scan #(
  parameter int CAPACITY = iolsu_pkg::CAPACITY,
  parameter int LANE     = iolsu_pkg::LANE,
  parameter int IDX_W    = 6,
  parameter int CHK_W    = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [CHK_W-1:0]               start_chunk_i,
  input  logic [CAPACITY-1:0]            match_i,
  input  logic [iolsu_pkg::DATA_W-1:0]   data_i [CAPACITY],
  output iolsu_pkg::scan_res_t           res_o,
  output logic [IDX_W-1:0]               pos_o
);

  localparam int LANE_W = $clog2(LANE);
  localparam int NCHUNK = (CAPACITY + LANE - 1) / LANE;
  localparam int PAD    = LANE << CHK_W;
  localparam logic [CHK_W-1:0] LAST_CHUNK = CHK_W'(NCHUNK - 1);

  logic [PAD-1:0]                match_pad;
  logic [iolsu_pkg::DATA_W-1:0]  data_pad [PAD];

  for (genvar g = 0; g < PAD; g++) begin : g_pad
    if (g < CAPACITY) begin : g_live
      assign match_pad[g] = match_i[g];
      assign data_pad[g]  = data_i[g];
    end else begin : g_zero
      assign match_pad[g] = 1'b0;
      assign data_pad[g]  = '0;
    end
  end

  logic                          busy_q;
  logic [CHK_W-1:0]              chunk_q;
  logic                          done_q;
  logic                          found_q;
  logic [iolsu_pkg::DATA_W-1:0]  data_q;
  logic [IDX_W-1:0]              pos_q;

  logic                          lane_any;
  logic [LANE_W-1:0]             lane_first;
  logic [iolsu_pkg::DATA_W-1:0]  lane_data;
  logic                          lane_done;

  always_comb begin
    lane_any   = 1'b0;
    lane_first = '0;
    lane_data  = '0;
    for (int j = LANE - 1; j >= 0; j--) begin
      if (match_pad[{chunk_q, LANE_W'(j)}]) begin
        lane_any   = 1'b1;
        lane_first = LANE_W'(j);
        lane_data  = lane_data | data_pad[{chunk_q, LANE_W'(j)}];
      end
    end
    lane_done = lane_any || (chunk_q == LAST_CHUNK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && lane_done) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Advance one lane a cycle until a match or the last lane.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      chunk_q <= start_chunk_i;
    end else if (busy_q && !lane_done) begin
      chunk_q <= chunk_q + CHK_W'(1);
    end
    if (busy_q && lane_done) begin
      found_q <= lane_any;
      data_q  <= lane_data;
      pos_q   <= IDX_W'({chunk_q, lane_first});
    end
  end

  assign res_o.done  = done_q;
  assign res_o.found = found_q;
  assign res_o.data  = data_q;
  assign pos_o       = pos_q;

endmodule

// ===== src/indexed_ordered_list_store_unit.sv =====
// Top level of the indexed ordered list store: control, cell row and scan unit.
//
//   channel | direction | payload            | handshake
//   --------+-----------+--------------------+-------------------------------
//   in      | request   | in_req_i  (req_t)  | in_valid_i  / in_stall_o
//   out     | result    | out_rsp_o (rsp_t)  | out_valid_o / out_stall_i
//
// One request at a time. Push, append, insert and length pass through the
// result register and the hold state to the output register; the cells from
// the insert point on shift in the accept cycle. Get and find scan the cell
// row LANE cells a cycle; get starts at its position's lane, find at the first.
// Reset empties the list at once; entries need no clearing.
// A result waiting under out_stall_i lets one more request in; that request's
// result is held, and the input stalled, until the output register drains.
module indexed_ordered_list_store_unit #(
  parameter int CAPACITY = iolsu_pkg::CAPACITY,
  parameter int LANE     = iolsu_pkg::LANE
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  iolsu_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output iolsu_pkg::rsp_t out_rsp_o
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LANE_W = $clog2(LANE);
  localparam int NCHUNK = (CAPACITY + LANE - 1) / LANE;
  localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int DW     = iolsu_pkg::DATA_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             find_q;
  logic [DW-1:0]    key_q;
  logic [6:0]       pos_q;
  iolsu_pkg::rsp_t  res_q;
  iolsu_pkg::rsp_t  out_q;
  logic             out_valid_q;

  logic             accept;
  logic             full;
  logic             is_empty;
  logic             upd;
  logic [CNT_W-1:0] ins_pos;
  logic             need_scan;
  logic [2:0]       acc_status;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [IDX_W-1:0] rd_idx;
  logic [CHK_W-1:0] start_chunk;
  logic             out_fire;

  logic [DW-1:0]         entry_w [CAPACITY];
  logic [CAPACITY-1:0]   match_w;
  iolsu_pkg::scan_res_t  scan_res;
  logic [IDX_W-1:0]      scan_pos;

  assign accept   = in_valid_i && !in_stall_o;
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign pos_ext  = CMP_W'(in_req_i.position);
  assign cnt_ext  = CMP_W'(count_q);
  assign rd_idx   = IDX_W'(in_req_i.position);
  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    upd        = 1'b0;
    ins_pos    = '0;
    need_scan  = 1'b0;
    acc_status = iolsu_pkg::ST_OK;
    start_chunk = '0;
    case (in_req_i.operation)
      iolsu_pkg::OP_PUSH_FRONT: begin
        if (full) acc_status = iolsu_pkg::ST_FULL;
        else upd = 1'b1;
      end
      iolsu_pkg::OP_APPEND: begin
        ins_pos = count_q;
        if (full) acc_status = iolsu_pkg::ST_FULL;
        else upd = 1'b1;
      end
      iolsu_pkg::OP_INSERT: begin
        ins_pos = CNT_W'(in_req_i.position);
        if (full) acc_status = iolsu_pkg::ST_FULL;
        else if (pos_ext > cnt_ext) acc_status = iolsu_pkg::ST_RANGE;
        else upd = 1'b1;
      end
      iolsu_pkg::OP_GET: begin
        start_chunk = CHK_W'(rd_idx >> LANE_W);
        if (is_empty) acc_status = iolsu_pkg::ST_EMPTY;
        else if (pos_ext >= cnt_ext) acc_status = iolsu_pkg::ST_RANGE;
        else need_scan = 1'b1;
      end
      iolsu_pkg::OP_FIND: begin
        if (is_empty) acc_status = iolsu_pkg::ST_EMPTY;
        else need_scan = 1'b1;
      end
      default: begin
        acc_status = iolsu_pkg::ST_OK;
      end
    endcase
    upd     = upd && accept;
    count_d = upd ? count_q + CNT_W'(1) : count_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = need_scan ? S_SCAN : S_HOLD;
      end
      S_SCAN: begin
        if (scan_res.done) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_q || out_fire) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_HOLD && (!out_valid_q || out_fire)) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      find_q                  <= (in_req_i.operation == iolsu_pkg::OP_FIND);
      key_q                   <= in_req_i.value;
      pos_q                   <= in_req_i.position;
      res_q.status            <= acc_status;
      res_q.read_value        <= '0;
      res_q.found_position    <= '0;
      res_q.length            <= 7'(count_d);
    end else if (state_q == S_SCAN && scan_res.done) begin
      res_q.status <= scan_res.found ? iolsu_pkg::ST_OK : iolsu_pkg::ST_NOTFOUND;
      if (find_q) begin
        res_q.found_position <= scan_res.found ? 6'(scan_pos) : 6'd0;
      end else begin
        res_q.read_value <= scan_res.data;
      end
    end
    if (state_q == S_HOLD && (!out_valid_q || out_fire)) begin
      out_q <= res_q;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] left;
    if (g == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = entry_w[g-1];
    end
    iolsu_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk_i     (clk_i),
      .upd_i     (upd),
      .ins_pos_i (ins_pos),
      .value_i   (in_req_i.value),
      .left_i    (left),
      .count_i   (count_q),
      .find_i    (find_q),
      .key_i     (key_q),
      .rd_pos_i  (CNT_W'(pos_q)),
      .entry_o   (entry_w[g]),
      .match_o   (match_w[g])
    );
  end

  iolsu_scan #(
    .CAPACITY (CAPACITY),
    .LANE     (LANE),
    .IDX_W    (IDX_W),
    .CHK_W    (CHK_W)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept && need_scan),
    .start_chunk_i (start_chunk),
    .match_i       (match_w),
    .data_i        (entry_w),
    .res_o         (scan_res),
    .pos_o         (scan_pos)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== tb/indexed_ordered_list_store_unit_tb.sv =====
// Self-checking testbench for the indexed ordered list store: directed and random requests.
`timescale 1ns / 1ps

module indexed_ordered_list_store_unit_tb;

  // Codes 6 and 7 behave as a length query
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_REQS = 1030;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 30;

  class list_scoreboard;
    logic signed [iolsu_pkg::DATA_W-1:0] cells[$];
    iolsu_pkg::rsp_t                     expected_q[$];
    int                                  errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its result
    function void note_request(iolsu_pkg::req_t r);
      iolsu_pkg::rsp_t e;
      int              k;
      bit              hit;
      e = '0;
      e.status = iolsu_pkg::ST_OK;
      case (r.operation)
        iolsu_pkg::OP_PUSH_FRONT: begin
          if (cells.size() >= iolsu_pkg::CAPACITY) e.status = iolsu_pkg::ST_FULL;
          else cells.push_front(r.value);
        end
        iolsu_pkg::OP_APPEND: begin
          if (cells.size() >= iolsu_pkg::CAPACITY) e.status = iolsu_pkg::ST_FULL;
          else cells.push_back(r.value);
        end
        iolsu_pkg::OP_INSERT: begin
          if (cells.size() >= iolsu_pkg::CAPACITY) e.status = iolsu_pkg::ST_FULL;
          else if (r.position > cells.size()) e.status = iolsu_pkg::ST_RANGE;
          else if (r.position == cells.size()) cells.push_back(r.value);
          else cells.insert(r.position, r.value);
        end
        iolsu_pkg::OP_GET: begin
          if (cells.size() == 0) e.status = iolsu_pkg::ST_EMPTY;
          else if (r.position >= cells.size()) e.status = iolsu_pkg::ST_RANGE;
          else e.read_value = cells[r.position];
        end
        iolsu_pkg::OP_FIND: begin
          if (cells.size() == 0) begin
            e.status = iolsu_pkg::ST_EMPTY;
          end else begin
            hit = 1'b0;
            for (k = 0; k < cells.size() && !hit; k++) begin
              if (cells[k] == r.value) begin
                e.found_position = k[5:0];
                hit = 1'b1;
              end
            end
            if (!hit) e.status = iolsu_pkg::ST_NOTFOUND;
          end
        end
        default: ;
      endcase
      e.length = 7'(cells.size());
      expected_q.push_back(e);
    endfunction

    function void check_result(iolsu_pkg::rsp_t got);
      iolsu_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d length %0d", got.status, got.length);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.read_value !== e.read_value) begin
        $error("read_value: expected %0d, actual %0d", e.read_value, got.read_value);
        errors++;
      end
      if (got.found_position !== e.found_position) begin
        $error("found_position: expected %0d, actual %0d",
               e.found_position, got.found_position);
        errors++;
      end
      if (got.length !== e.length) begin
        $error("length: expected %0d, actual %0d", e.length, got.length);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  iolsu_pkg::req_t in_req_i    = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  iolsu_pkg::rsp_t out_rsp_o;

  list_scoreboard sb = new();

  bit          no_idle    = 1'b0;
  bit          hold_start = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned cycles     = 0;

  indexed_ordered_list_store_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
  end

  // Receiver: random stalls, none while no_idle is set, or a long hold-off once asked for
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 16);
    end
  end

  function automatic iolsu_pkg::req_t make_req(logic [2:0] op,
                                               logic [iolsu_pkg::DATA_W-1:0] v,
                                               logic [6:0] p);
    iolsu_pkg::req_t r;
    r.operation = op;
    r.value     = v;
    r.position  = p;
    return r;
  endfunction

  function automatic logic [iolsu_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return $urandom_range(0, 6) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, hold it until accepted, and at times drop valid for a random idle gap
  task automatic send(iolsu_pkg::req_t r);
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
    if (!no_idle && hold_left == 0 && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random();
    int unsigned                  roll;
    int unsigned                  fill;
    logic [2:0]                   op;
    logic [6:0]                   p;
    logic [iolsu_pkg::DATA_W-1:0] v;
    roll = $urandom_range(0, 99);
    fill = sb.cells.size();
    v    = pick_value();
    p    = 7'($urandom_range(0, 64));
    if (roll < 8) begin
      case ($urandom_range(0, 2))
        0:       op = iolsu_pkg::OP_PUSH_FRONT;
        1:       op = iolsu_pkg::OP_APPEND;
        default: op = iolsu_pkg::OP_INSERT;
      endcase
      if (op == iolsu_pkg::OP_INSERT && $urandom_range(0, 9) != 0) begin
        p = 7'($urandom_range(0, fill + 1));
      end
    end else if (roll < 45) begin
      op = iolsu_pkg::OP_GET;
      if (fill != 0 && $urandom_range(0, 4) != 0) p = 7'($urandom_range(0, fill - 1));
    end else if (roll < 85) begin
      op = iolsu_pkg::OP_FIND;
      if (fill != 0 && $urandom_range(0, 9) < 6) v = sb.cells[$urandom_range(0, fill - 1)];
    end else begin
      case ($urandom_range(0, 2))
        0:       op = iolsu_pkg::OP_LENGTH;
        1:       op = OP_SPARE_LO;
        default: op = OP_SPARE_HI;
      endcase
    end
    send(make_req(op, v, p));
  endtask

  initial begin
    bit failed;
    int i;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list corner cases
    send(make_req(iolsu_pkg::OP_LENGTH, 32'd0, 7'd0));
    send(make_req(iolsu_pkg::OP_GET, 32'd0, 7'd0));
    send(make_req(iolsu_pkg::OP_FIND, 32'd0, 7'd0));
    send(make_req(iolsu_pkg::OP_INSERT, 32'd5, 7'd1));
    // Push onto an empty list, then append
    send(make_req(iolsu_pkg::OP_PUSH_FRONT, 32'h7fff_ffff, 7'd0));
    send(make_req(iolsu_pkg::OP_APPEND, 32'h8000_0000, 7'd0));
    // Insert at the front goes in once; insert at the end appends
    send(make_req(iolsu_pkg::OP_INSERT, 32'hffff_ffff, 7'd0));
    send(make_req(iolsu_pkg::OP_INSERT, 32'd0, 7'd3));
    send(make_req(iolsu_pkg::OP_INSERT, 32'd9, 7'd5));
    send(make_req(iolsu_pkg::OP_INSERT, 32'd12345, 7'd2));
    send(make_req(iolsu_pkg::OP_GET, 32'd0, 7'd0));
    send(make_req(iolsu_pkg::OP_GET, 32'd0, 7'd4));
    send(make_req(iolsu_pkg::OP_GET, 32'd0, 7'd5));
    send(make_req(iolsu_pkg::OP_GET, 32'd0, 7'd64));
    send(make_req(iolsu_pkg::OP_GET, 32'd0, 7'd63));
    send(make_req(iolsu_pkg::OP_APPEND, 32'hffff_ffff, 7'd0));
    send(make_req(iolsu_pkg::OP_FIND, 32'hffff_ffff, 7'd0));
    send(make_req(iolsu_pkg::OP_FIND, 32'h8000_0000, 7'd0));
    send(make_req(iolsu_pkg::OP_FIND, 32'd7, 7'd0));
    send(make_req(OP_SPARE_LO, 32'd1, 7'd1));
    send(make_req(OP_SPARE_HI, 32'hffff_ffff, 7'd64));
    send(make_req(iolsu_pkg::OP_LENGTH, 32'h8000_0000, 7'd127));

    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i == 100) hold_start = 1'b1;
      if (i == 250 || i == 900) drain();
      no_idle = (i >= 600 && i < 800);
      send_random();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    failed = (sb.errors != 0) || (sb.pending() != 0);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
